@@ rtl/core/tpc_pkg.sv @@
// Package for the three-layer pixel compositor.
// Holds the beat structs, the blend path codes and the channel arithmetic helpers.
// No dependencies.
package tpc_pkg;

	localparam logic [7:0] CH_MAX = 8'hFF;

	typedef struct packed {
		logic        last_pixel;
		logic [31:0] background_rgba;
		logic [31:0] character_rgba;
		logic [31:0] frame_rgba;
	} pixel_t;

	typedef struct packed {
		logic [31:0] composite_rgba;
		logic        last_pixel_out;
	} result_t;

	typedef enum logic [1:0] {
		PATH_FRAME = 2'd0,
		PATH_CHAR  = 2'd1,
		PATH_BG    = 2'd2,
		PATH_BLEND = 2'd3
	} path_t;

	// Weighted sum top*a + bottom*(255-a); never exceeds 65025.
	function automatic logic [15:0] mix_sum(logic [7:0] top, logic [7:0] bottom,
		logic [7:0] a);
		logic [15:0] pt;
		logic [15:0] pb;
		logic [16:0] s;
		pt = 16'(top) * 16'(a);
		pb = 16'(bottom) * 16'(CH_MAX - a);
		s  = 17'(pt) + 17'(pb);
		return s[15:0];
	endfunction

	// Exact truncating division by 255 for inputs up to 65025.
	function automatic logic [7:0] div255(logic [15:0] x);
		logic [16:0] t;
		t = 17'(x) + 17'(x[15:8]) + 17'd1;
		return t[15:8];
	endfunction

endpackage

@@ rtl/core/three_layer_pixel_compositor.sv @@
// An accepted pixel beat is registered in stages 1, 2, 3 and 4 in turn; stage 4 drives the result beat.
// Throughput: one pixel per cycle while result_stall is low; each stage holds its beat only while the next one is full.
// Stage 1 blends character over background, stage 2 divides by 255 and picks the pass-through layer,
// stage 3 blends the frame over that, stage 4 divides again; the output selects blend or pass-through.
// Reset (arst_n low, asynchronous) clears all stage valid bits; no data is cleared.
// Depends on tpc_pkg.
module three_layer_pixel_compositor (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pixel_valid,
	output logic             pixel_stall,
	input  tpc_pkg::pixel_t  pixel,
	output logic             result_valid,
	input  logic             result_stall,
	output tpc_pkg::result_t result
);
	import tpc_pkg::*;

	logic en1, en2, en3, en4;
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	path_t       path_c;
	logic [7:0]  fa_c, ca_c;
	logic [15:0] sum1_c [3];
	logic [7:0]  mid_c [3];
	logic [31:0] pass_c;
	logic [15:0] sum3_c [3];
	logic [7:0]  out_c [3];

	path_t       path_s1, path_s2, path_s3, path_s4;
	logic        last_s1, last_s2, last_s3, last_s4;
	logic [31:0] frame_s1, frame_s2;
	logic [31:0] char_s1, bg_s1;
	logic [15:0] sum_s1 [3];
	logic [7:0]  mid_s2 [3];
	logic [31:0] pass_s2, pass_s3, pass_s4;
	logic [15:0] sum_s3 [3];
	logic [31:0] comp_s4;

	assign en4 = !valid_s4 || !result_stall;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign pixel_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= pixel_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
		end
	end

	always_comb begin
		fa_c = pixel.frame_rgba[31:24];
		ca_c = pixel.character_rgba[31:24];
		priority if (fa_c == CH_MAX) begin
			path_c = PATH_FRAME;
		end else if (fa_c == 8'd0 && ca_c == CH_MAX) begin
			path_c = PATH_CHAR;
		end else if (fa_c == 8'd0 && ca_c == 8'd0) begin
			path_c = PATH_BG;
		end else begin
			path_c = PATH_BLEND;
		end
		for (int i = 0; i < 3; i++) begin
			sum1_c[i] = mix_sum(pixel.character_rgba[8*i +: 8],
				pixel.background_rgba[8*i +: 8], ca_c);
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			path_s1  <= path_c;
			last_s1  <= pixel.last_pixel;
			frame_s1 <= pixel.frame_rgba;
			char_s1  <= pixel.character_rgba;
			bg_s1    <= pixel.background_rgba;
			sum_s1   <= sum1_c;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mid_c[i] = div255(sum_s1[i]);
		end
		unique case (path_s1)
			PATH_FRAME: pass_c = frame_s1;
			PATH_CHAR:  pass_c = char_s1;
			PATH_BG:    pass_c = bg_s1;
			PATH_BLEND: pass_c = frame_s1;
			default:    pass_c = frame_s1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			path_s2  <= path_s1;
			last_s2  <= last_s1;
			frame_s2 <= frame_s1;
			mid_s2   <= mid_c;
			pass_s2  <= pass_c;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum3_c[i] = mix_sum(frame_s2[8*i +: 8], mid_s2[i], frame_s2[31:24]);
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			path_s3 <= path_s2;
			last_s3 <= last_s2;
			pass_s3 <= pass_s2;
			sum_s3  <= sum3_c;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			out_c[i] = div255(sum_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			path_s4 <= path_s3;
			last_s4 <= last_s3;
			pass_s4 <= pass_s3;
			comp_s4 <= {CH_MAX, out_c[2], out_c[1], out_c[0]};
		end
	end

	assign result_valid          = valid_s4;
	assign result.composite_rgba = (path_s4 == PATH_BLEND) ? comp_s4 : pass_s4;
	assign result.last_pixel_out = last_s4;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && result_stall))
		else $error("input stalled while the pipeline has a free stage");

	a_blend_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && path_s4 == PATH_BLEND) |-> (result.composite_rgba[31:24] == CH_MAX))
		else $error("blended result is not opaque");

	a_stage1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !en2) |=> (valid_s1 && $stable(path_s1) && $stable(frame_s1)
			&& $stable(last_s1)))
		else $error("stage 1 beat changed while held");

	a_stage3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !en4) |=> (valid_s3 && $stable(path_s3) && $stable(pass_s3)
			&& $stable(last_s3)))
		else $error("stage 3 beat changed while held");

endmodule
